### hdl/cgpl_pkg.sv
package cgpl_pkg;

    localparam int unsigned NUM_SLOTS_DEF = 2048;

    localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;
    localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;

    localparam logic [31:0] MIN_INTERVAL_RST = 32'd100;
    localparam logic [31:0] MAX_INTERVAL_RST = 32'd0;

    // Configuration register indexes
    localparam logic REG_MIN_INTERVAL = 1'b0;
    localparam logic REG_MAX_INTERVAL = 1'b1;

    typedef enum logic {
        FUNC_BYTE   = 1'b0,
        FUNC_DECIDE = 1'b1
    } func_t;

    typedef enum logic [1:0] {
        REASON_HELD        = 2'd0,
        REASON_FORCED      = 2'd1,
        REASON_MAX_EXPIRED = 2'd2,
        REASON_CHANGED     = 2'd3
    } push_reason_t;

    // Slot history write request from the decision stage
    typedef struct packed {
        logic time_we;
        logic crc_we;
    } hist_wr_t;

    // Occupancy of the decision stage
    typedef struct packed {
        logic valid;
        logic advance;
    } stage_status_t;

    // One byte of reflected CRC-32, eight shift steps of the table entry
    function automatic logic [31:0] crc_step(input logic [31:0] crc, input logic [7:0] data);
        logic [31:0] t;
        t = {24'd0, crc[7:0] ^ data};
        for (int k = 0; k < 8; k++)
        begin
            t = t[0] ? ((t >> 1) ^ CRC_POLY) : (t >> 1);
        end
        return t ^ (crc >> 8);
    endfunction

endpackage

### hdl/cgpl_ram.sv
// Single-port-write, single-port-read memory with registered read data.
// A read that meets a write to the same address returns the new data.
module cgpl_ram #(
    parameter int unsigned Depth = cgpl_pkg::NUM_SLOTS_DEF,
    parameter int unsigned Width = 32,
    parameter int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  logic [AddrW-1:0] wr_addr,
    input  logic [Width-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AddrW-1:0] rd_addr,
    output logic [Width-1:0] rd_data
);

    logic [Width-1:0] mem [Depth];
    logic [Width-1:0] rd_data_reg;
    logic [Width-1:0] byp_data_reg;
    logic             byp_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg  <= mem[rd_addr];
            byp_data_reg <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byp_reg <= 1'b0;
        end
        else if (rd_en)
        begin
            byp_reg <= wr_en && (wr_addr == rd_addr);
        end
    end

    assign rd_data = byp_reg ? byp_data_reg : rd_data_reg;

endmodule

### hdl/cgpl_crc.sv
// Running CRC-32 over the byte stream; restart on every decision.
module cgpl_crc (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        byte_en,
    input  logic        restart,
    input  logic [7:0]  data_byte,
    input  logic        segment_end,
    output logic [31:0] crc_value
);

    logic [31:0] crc_reg;
    logic [31:0] crc_next;
    logic [31:0] crc_stepped;

    assign crc_stepped = cgpl_pkg::crc_step(crc_reg, data_byte);

    always_comb
    begin
        crc_next = crc_reg;
        priority if (restart)
        begin
            crc_next = cgpl_pkg::CRC_INIT;
        end
        else if (byte_en)
        begin
            crc_next = segment_end ? ~crc_stepped : crc_stepped;
        end
        else
        begin
            crc_next = crc_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crc_reg <= cgpl_pkg::CRC_INIT;
        end
        else
        begin
            crc_reg <= crc_next;
        end
    end

    assign crc_value = crc_reg;

endmodule

### hdl/cgpl_decide.sv
// Decision stage: holds one request while the slot history is read,
// decides, issues the history write and fills the result register.
module cgpl_decide #(
    parameter int unsigned AddrW = 11
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    load,
    input  logic [AddrW-1:0]        slot_addr,
    input  logic                    slot_in_range,
    input  logic [31:0]             now_ms,
    input  logic                    force_req,
    input  logic                    skip_check,
    input  logic [31:0]             crc_snap,
    input  logic [31:0]             hist_time,
    input  logic [31:0]             hist_crc,
    input  logic [31:0]             min_interval,
    input  logic [31:0]             max_interval,
    input  logic                    out_ready,
    output logic                    out_valid,
    output logic                    push_res,
    output logic [1:0]              push_reason,
    output cgpl_pkg::stage_status_t status,
    output cgpl_pkg::hist_wr_t      hist_wr,
    output logic [AddrW-1:0]        wr_addr,
    output logic [31:0]             wr_time,
    output logic [31:0]             wr_crc
);

    logic                   s1_valid_reg;
    logic [AddrW-1:0]       s1_addr_reg;
    logic                   s1_in_range_reg;
    logic [31:0]            s1_now_reg;
    logic                   s1_force_reg;
    logic                   s1_skip_reg;
    logic [31:0]            s1_crc_reg;
    logic                   out_valid_reg;
    logic                   out_res_reg;
    logic [1:0]             out_reason_reg;

    logic                   s1_adv;
    logic [31:0]            elapsed;
    cgpl_pkg::push_reason_t reason;
    logic                   push;

    assign s1_adv  = s1_valid_reg && (!out_valid_reg || out_ready);
    assign elapsed = s1_now_reg - hist_time;

    always_comb
    begin
        reason = cgpl_pkg::REASON_HELD;
        priority if (!s1_in_range_reg)
        begin
            reason = cgpl_pkg::REASON_HELD;
        end
        else if (s1_force_reg)
        begin
            reason = cgpl_pkg::REASON_FORCED;
        end
        else if ((max_interval != 32'd0) && (elapsed > max_interval))
        begin
            reason = cgpl_pkg::REASON_MAX_EXPIRED;
        end
        else if ((elapsed <= min_interval) || s1_skip_reg)
        begin
            reason = cgpl_pkg::REASON_HELD;
        end
        else if (hist_crc != s1_crc_reg)
        begin
            reason = cgpl_pkg::REASON_CHANGED;
        end
        else
        begin
            reason = cgpl_pkg::REASON_HELD;
        end
    end

    assign push = (reason != cgpl_pkg::REASON_HELD);

    assign hist_wr.time_we = s1_adv && push;
    assign hist_wr.crc_we  = s1_adv && (reason == cgpl_pkg::REASON_CHANGED);
    assign wr_addr         = s1_addr_reg;
    assign wr_time         = s1_now_reg;
    assign wr_crc          = s1_crc_reg;

    assign status.valid   = s1_valid_reg;
    assign status.advance = s1_adv;

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            s1_addr_reg     <= slot_addr;
            s1_in_range_reg <= slot_in_range;
            s1_now_reg      <= now_ms;
            s1_force_reg    <= force_req;
            s1_skip_reg     <= skip_check;
            s1_crc_reg      <= crc_snap;
        end
        if (s1_adv)
        begin
            out_res_reg    <= push;
            out_reason_reg <= reason;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (load)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_adv)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (s1_adv)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid   = out_valid_reg;
    assign push_res    = out_res_reg;
    assign push_reason = out_reason_reg;

endmodule

### hdl/change_gated_push_limiter.sv
// Channel   Handshake            Payload
// --------  -------------------  ---------------------------------------------------
// in        in_valid / in_ready  func, data_byte, segment_end, object_slot, now_ms,
//                                force_req, skip_check
// out       out_valid/out_ready  push_res, push_reason
// cfg       cfg_we (no wait)     cfg_index, cfg_data
//
// One input transfer per cycle while in_ready is high. A data byte updates
// the running CRC at its transfer and produces nothing; a decision is held
// in the decision stage while the slot history is read, and its result is
// then registered in the output register. After reset a clearing pass
// zeroes the slot history, during which in_ready stays low; configuration
// writes are taken as ever. A stalled output holds the decision stage;
// outside the clearing pass, in_ready falls only when that stage is full
// and cannot advance.
module change_gated_push_limiter #(
    parameter int unsigned NumSlots = cgpl_pkg::NUM_SLOTS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,

    input  logic        in_valid,
    output logic        in_ready,
    input  logic        func,
    input  logic [7:0]  data_byte,
    input  logic        segment_end,
    input  logic [10:0] object_slot,
    input  logic [31:0] now_ms,
    input  logic        force_req,
    input  logic        skip_check,

    output logic        out_valid,
    input  logic        out_ready,
    output logic        push_res,
    output logic [1:0]  push_reason,

    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [31:0] cfg_data
);

    localparam int unsigned AddrW = (NumSlots > 1) ? $clog2(NumSlots) : 1;

    // Configuration registers
    logic [31:0] min_interval_reg;
    logic [31:0] max_interval_reg;

    // Clearing pass over the slot history
    logic             clear_busy_reg;
    logic [AddrW-1:0] clr_addr_reg;

    logic                    in_xfer;
    logic                    byte_xfer;
    logic                    dec_xfer;
    logic [AddrW-1:0]        rd_addr;
    logic                    slot_in_range;
    logic [31:0]             crc_value;
    logic [31:0]             hist_time;
    logic [31:0]             hist_crc;
    cgpl_pkg::stage_status_t dec_status;
    cgpl_pkg::hist_wr_t      dec_wr;
    logic [AddrW-1:0]        dec_addr;
    logic [31:0]             dec_time;
    logic [31:0]             dec_crc;

    logic                    time_we;
    logic                    crc_we;
    logic [AddrW-1:0]        wr_addr;
    logic [31:0]             time_wdata;
    logic [31:0]             crc_wdata;

    // Accept when not clearing and the decision stage is free or draining
    assign in_ready  = !clear_busy_reg && (!dec_status.valid || dec_status.advance);
    assign in_xfer   = in_valid && in_ready;
    assign byte_xfer = in_xfer && (func == cgpl_pkg::FUNC_BYTE);
    assign dec_xfer  = in_xfer && (func == cgpl_pkg::FUNC_DECIDE);

    assign rd_addr       = AddrW'(object_slot);
    assign slot_in_range = (32'(object_slot) < 32'(NumSlots));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_interval_reg <= cgpl_pkg::MIN_INTERVAL_RST;
            max_interval_reg <= cgpl_pkg::MAX_INTERVAL_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                cgpl_pkg::REG_MIN_INTERVAL: min_interval_reg <= cfg_data;
                cgpl_pkg::REG_MAX_INTERVAL: max_interval_reg <= cfg_data;
                default:                    min_interval_reg <= min_interval_reg;
            endcase
        end
    end

    // Sweep every slot to zero once after reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_busy_reg <= 1'b1;
            clr_addr_reg   <= '0;
        end
        else if (clear_busy_reg)
        begin
            if (clr_addr_reg == AddrW'(NumSlots - 1))
            begin
                clear_busy_reg <= 1'b0;
            end
            else
            begin
                clr_addr_reg <= clr_addr_reg + 1'b1;
            end
        end
    end

    // History write port: clearing pass first, decisions otherwise
    assign time_we    = clear_busy_reg || dec_wr.time_we;
    assign crc_we     = clear_busy_reg || dec_wr.crc_we;
    assign wr_addr    = clear_busy_reg ? clr_addr_reg : dec_addr;
    assign time_wdata = clear_busy_reg ? 32'd0 : dec_time;
    assign crc_wdata  = clear_busy_reg ? 32'd0 : dec_crc;

    cgpl_crc u_crc (
        .clk         (clk),
        .rst_n       (rst_n),
        .byte_en     (byte_xfer),
        .restart     (dec_xfer),
        .data_byte   (data_byte),
        .segment_end (segment_end),
        .crc_value   (crc_value)
    );

    cgpl_ram #(
        .Depth (NumSlots),
        .Width (32),
        .AddrW (AddrW)
    ) u_time_ram (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (time_we),
        .wr_addr (wr_addr),
        .wr_data (time_wdata),
        .rd_en   (dec_xfer),
        .rd_addr (rd_addr),
        .rd_data (hist_time)
    );

    cgpl_ram #(
        .Depth (NumSlots),
        .Width (32),
        .AddrW (AddrW)
    ) u_crc_ram (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (crc_we),
        .wr_addr (wr_addr),
        .wr_data (crc_wdata),
        .rd_en   (dec_xfer),
        .rd_addr (rd_addr),
        .rd_data (hist_crc)
    );

    cgpl_decide #(
        .AddrW (AddrW)
    ) u_decide (
        .clk           (clk),
        .rst_n         (rst_n),
        .load          (dec_xfer),
        .slot_addr     (rd_addr),
        .slot_in_range (slot_in_range),
        .now_ms        (now_ms),
        .force_req     (force_req),
        .skip_check    (skip_check),
        .crc_snap      (crc_value),
        .hist_time     (hist_time),
        .hist_crc      (hist_crc),
        .min_interval  (min_interval_reg),
        .max_interval  (max_interval_reg),
        .out_ready     (out_ready),
        .out_valid     (out_valid),
        .push_res      (push_res),
        .push_reason   (push_reason),
        .status        (dec_status),
        .hist_wr       (dec_wr),
        .wr_addr       (dec_addr),
        .wr_time       (dec_time),
        .wr_crc        (dec_crc)
    );

    // No transfer may slip in while the history is being cleared
    assert property (@(posedge clk) disable iff (!rst_n)
        clear_busy_reg |-> !in_ready)
        else $error("input accepted during clearing pass");

    // A decision write never collides with the clearing pass
    assert property (@(posedge clk) disable iff (!rst_n)
        clear_busy_reg |-> (!dec_wr.time_we && !dec_wr.crc_we))
        else $error("decision write during clearing pass");

    // A stored CRC always comes with a stored push time
    assert property (@(posedge clk) disable iff (!rst_n)
        dec_wr.crc_we |-> dec_wr.time_we)
        else $error("CRC stored without push time");

    // Push flag and reason agree in every result
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (push_res == (push_reason != 2'(cgpl_pkg::REASON_HELD))))
        else $error("push flag disagrees with reason");

    // Every decision restarts the running CRC
    assert property (@(posedge clk) disable iff (!rst_n)
        dec_xfer |=> (crc_value == cgpl_pkg::CRC_INIT))
        else $error("running CRC not restarted after decision");

endmodule
